/* rtl/roe_pkg.sv */
// Shared types, constants and the microcode table of the resistance estimator.
package roe_pkg;

	typedef logic [63:0] word_t;
	typedef logic [3:0]  op_t;
	typedef logic [3:0]  reg_t;
	typedef logic [1:0]  sh_t;
	typedef logic [5:0]  pc_t;

	// operations
	localparam op_t OP_LDI   = 4'd0;
	localparam op_t OP_CUR   = 4'd1;
	localparam op_t OP_VOLT  = 4'd2;
	localparam op_t OP_ADD   = 4'd3;
	localparam op_t OP_SUB   = 4'd4;
	localparam op_t OP_SAT48 = 4'd5;
	localparam op_t OP_MUL   = 4'd6;
	localparam op_t OP_DIV   = 4'd7;
	localparam op_t OP_PUB   = 4'd8;

	// register file slots
	localparam reg_t R_C00 = 4'd0;
	localparam reg_t R_C01 = 4'd1;
	localparam reg_t R_C10 = 4'd2;
	localparam reg_t R_C11 = 4'd3;
	localparam reg_t R_OCV = 4'd4;
	localparam reg_t R_RES = 4'd5;
	localparam reg_t R_CUR = 4'd6;
	localparam reg_t R_PA0 = 4'd7;
	localparam reg_t R_PA1 = 4'd8;
	localparam reg_t R_DEN = 4'd9;
	localparam reg_t R_K0  = 4'd10;
	localparam reg_t R_K1  = 4'd11;
	localparam reg_t R_ERR = 4'd12;
	localparam reg_t R_Q0  = 4'd13;
	localparam reg_t R_Q1  = 4'd14;
	localparam reg_t R_T   = 4'd15;

	// product shift codes
	localparam sh_t SH_0  = 2'd0;
	localparam sh_t SH_16 = 2'd1;
	localparam sh_t SH_32 = 2'd2;

	localparam word_t COV_INIT = 64'd65536000000;
	localparam word_t ONE_Q16  = 64'd65536;
	localparam word_t EST_MAX  = 64'h0000_7FFF_FFFF_FFFF;
	localparam word_t EST_MIN  = 64'hFFFF_8000_0000_0000;

	localparam pc_t INIT_PC = 6'd0;
	localparam pc_t ITEM_PC = 6'd6;

	typedef struct packed {
		op_t   op;
		reg_t  ra;
		reg_t  rb;
		reg_t  dst;
		sh_t   sh;
		word_t imm;
		logic  last;
	} uop_t;

	typedef struct packed {
		logic  rd_en;
		reg_t  ra;
		reg_t  rb;
		logic  start;
		op_t   op;
		reg_t  dst;
		sh_t   sh;
		word_t imm;
		logic  capture;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
	} dp_stat_t;

	function automatic uop_t mk(op_t op, reg_t ra, reg_t rb, reg_t dst, sh_t sh,
			word_t imm, logic last);
		uop_t u;
		u.op   = op;
		u.ra   = ra;
		u.rb   = rb;
		u.dst  = dst;
		u.sh   = sh;
		u.imm  = imm;
		u.last = last;
		return u;
	endfunction

	// init program at 0..5, per-sample program from ITEM_PC
	function automatic uop_t ucode(pc_t pc);
		uop_t u;
		u = mk(OP_PUB, R_OCV, R_RES, R_T, SH_0, '0, 1'b1);
		case (pc)
			6'd0:  u = mk(OP_LDI,   R_T,   R_T,   R_C00, SH_0,  COV_INIT, 1'b0);
			6'd1:  u = mk(OP_LDI,   R_T,   R_T,   R_C11, SH_0,  COV_INIT, 1'b0);
			6'd2:  u = mk(OP_LDI,   R_T,   R_T,   R_C01, SH_0,  '0,       1'b0);
			6'd3:  u = mk(OP_LDI,   R_T,   R_T,   R_C10, SH_0,  '0,       1'b0);
			6'd4:  u = mk(OP_LDI,   R_T,   R_T,   R_OCV, SH_0,  '0,       1'b0);
			6'd5:  u = mk(OP_LDI,   R_T,   R_T,   R_RES, SH_0,  '0,       1'b1);
			6'd6:  u = mk(OP_CUR,   R_T,   R_T,   R_CUR, SH_0,  '0,       1'b0);
			6'd7:  u = mk(OP_MUL,   R_C01, R_CUR, R_T,   SH_0,  '0,       1'b0);
			6'd8:  u = mk(OP_ADD,   R_C00, R_T,   R_PA0, SH_0,  '0,       1'b0);
			6'd9:  u = mk(OP_MUL,   R_C11, R_CUR, R_T,   SH_0,  '0,       1'b0);
			6'd10: u = mk(OP_ADD,   R_C10, R_T,   R_PA1, SH_0,  '0,       1'b0);
			6'd11: u = mk(OP_MUL,   R_PA1, R_CUR, R_T,   SH_0,  '0,       1'b0);
			6'd12: u = mk(OP_ADD,   R_PA0, R_T,   R_DEN, SH_0,  '0,       1'b0);
			6'd13: u = mk(OP_LDI,   R_T,   R_T,   R_T,   SH_0,  ONE_Q16,  1'b0);
			6'd14: u = mk(OP_ADD,   R_DEN, R_T,   R_DEN, SH_0,  '0,       1'b0);
			6'd15: u = mk(OP_DIV,   R_PA0, R_DEN, R_K0,  SH_0,  '0,       1'b0);
			6'd16: u = mk(OP_DIV,   R_PA1, R_DEN, R_K1,  SH_0,  '0,       1'b0);
			6'd17: u = mk(OP_VOLT,  R_T,   R_T,   R_ERR, SH_0,  '0,       1'b0);
			6'd18: u = mk(OP_SUB,   R_ERR, R_OCV, R_ERR, SH_0,  '0,       1'b0);
			6'd19: u = mk(OP_MUL,   R_RES, R_CUR, R_T,   SH_16, '0,       1'b0);
			6'd20: u = mk(OP_SUB,   R_ERR, R_T,   R_ERR, SH_0,  '0,       1'b0);
			6'd21: u = mk(OP_MUL,   R_K0,  R_ERR, R_T,   SH_32, '0,       1'b0);
			6'd22: u = mk(OP_ADD,   R_OCV, R_T,   R_OCV, SH_0,  '0,       1'b0);
			6'd23: u = mk(OP_SAT48, R_OCV, R_T,   R_OCV, SH_0,  '0,       1'b0);
			6'd24: u = mk(OP_MUL,   R_K1,  R_ERR, R_T,   SH_16, '0,       1'b0);
			6'd25: u = mk(OP_ADD,   R_RES, R_T,   R_RES, SH_0,  '0,       1'b0);
			6'd26: u = mk(OP_SAT48, R_RES, R_T,   R_RES, SH_0,  '0,       1'b0);
			6'd27: u = mk(OP_MUL,   R_C10, R_CUR, R_T,   SH_0,  '0,       1'b0);
			6'd28: u = mk(OP_ADD,   R_C00, R_T,   R_Q0,  SH_0,  '0,       1'b0);
			6'd29: u = mk(OP_MUL,   R_C11, R_CUR, R_T,   SH_0,  '0,       1'b0);
			6'd30: u = mk(OP_ADD,   R_C01, R_T,   R_Q1,  SH_0,  '0,       1'b0);
			6'd31: u = mk(OP_MUL,   R_K0,  R_Q0,  R_T,   SH_32, '0,       1'b0);
			6'd32: u = mk(OP_SUB,   R_C00, R_T,   R_C00, SH_0,  '0,       1'b0);
			6'd33: u = mk(OP_MUL,   R_K0,  R_Q1,  R_T,   SH_32, '0,       1'b0);
			6'd34: u = mk(OP_SUB,   R_C01, R_T,   R_C01, SH_0,  '0,       1'b0);
			6'd35: u = mk(OP_MUL,   R_K1,  R_Q0,  R_T,   SH_32, '0,       1'b0);
			6'd36: u = mk(OP_SUB,   R_C10, R_T,   R_C10, SH_0,  '0,       1'b0);
			6'd37: u = mk(OP_MUL,   R_K1,  R_Q1,  R_T,   SH_32, '0,       1'b0);
			6'd38: u = mk(OP_SUB,   R_C11, R_T,   R_C11, SH_0,  '0,       1'b0);
			default: u = mk(OP_PUB, R_OCV, R_RES, R_T,   SH_0,  '0,       1'b1);
		endcase
		return u;
	endfunction

endpackage

/* rtl/roe_ctrl.sv */
// Microcode sequencer for the resistance estimator.
module roe_ctrl import roe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;
	localparam logic [1:0] ST_WAIT = 2'd3;

	logic [1:0] state_q;
	pc_t        pc_q;
	uop_t       u;

	always_comb begin
		u           = ucode(pc_q);
		in_stall    = (state_q != ST_IDLE);
		cmd.rd_en   = (state_q == ST_READ);
		cmd.ra      = u.ra;
		cmd.rb      = u.rb;
		cmd.start   = (state_q == ST_RUN);
		cmd.op      = u.op;
		cmd.dst     = u.dst;
		cmd.sh      = u.sh;
		cmd.imm     = u.imm;
		cmd.capture = in_valid && (state_q == ST_IDLE);
	end

	// reset starts the init program, which loads the state slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_READ;
			pc_q    <= INIT_PC;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pc_q    <= ITEM_PC;
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_RUN;
				ST_RUN:  state_q <= ST_WAIT;
				ST_WAIT: begin
					if (stat.done) begin
						if (u.last) begin
							state_q <= ST_IDLE;
						end else begin
							pc_q    <= pc_q + 6'd1;
							state_q <= ST_READ;
						end
					end
				end
			endcase
		end
	end

endmodule

/* rtl/roe_datapath.sv */
// Register file, shared multiplier, divider and saturating ALU.
module roe_datapath import roe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic signed [15:0] batt_current,
	input  logic [15:0]        batt_voltage,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [47:0] ocv_estimate,
	output logic signed [47:0] resistance_estimate
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_FIN  = 3'd1;
	localparam logic [2:0] PH_MUL  = 3'd2;
	localparam logic [2:0] PH_MSH  = 3'd3;
	localparam logic [2:0] PH_DIV  = 3'd4;
	localparam logic [2:0] PH_PACK = 3'd5;
	localparam logic [2:0] PH_PUB  = 3'd6;

	word_t          rf_q [16];
	word_t          rda_q, rdb_q;
	logic [15:0]    cur_q, volt_q;
	logic [2:0]     ph_q;
	reg_t           dst_q;
	sh_t            sh_q;
	logic           neg_q;
	word_t          am_q, bm_q, rem_q, res_q;
	logic [127:0]   acc_q;
	logic [95:0]    dvd_q;
	logic [6:0]     cnt_q;
	logic           out_valid_q;

	logic           slot_free;
	word_t          alu_res;
	logic [63:0]    pp;
	logic [127:0]   pp_sh;
	logic [127:0]   rnd;
	word_t          packed_res;
	logic [64:0]    rsh;
	logic           ge;
	logic [64:0]    rdiff;

	function automatic word_t mag(word_t x);
		return x[63] ? (~x + 64'd1) : x;
	endfunction

	function automatic word_t sat_sum(logic [64:0] s);
		if (s[64] != s[63]) begin
			return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		end
		return s[63:0];
	endfunction

	assign slot_free = !out_valid_q || !out_stall;
	assign stat.done = (ph_q == PH_FIN) || ((ph_q == PH_PUB) && slot_free);
	assign out_valid = out_valid_q;

	// combinational ALU operations
	always_comb begin
		unique case (cmd.op)
			OP_LDI:  alu_res = cmd.imm;
			OP_CUR:  alu_res = {{48{cur_q[15]}}, cur_q};
			OP_VOLT: alu_res = {32'd0, volt_q, 16'd0};
			OP_ADD:  alu_res = sat_sum({rda_q[63], rda_q} + {rdb_q[63], rdb_q});
			OP_SUB:  alu_res = sat_sum({rda_q[63], rda_q} - {rdb_q[63], rdb_q});
			OP_SAT48: begin
				if ($signed(rda_q) > $signed(EST_MAX)) alu_res = EST_MAX;
				else if ($signed(rda_q) < $signed(EST_MIN)) alu_res = EST_MIN;
				else alu_res = rda_q;
			end
			default: alu_res = rda_q;
		endcase
	end

	// one 32x32 partial product per cycle
	always_comb begin
		pp    = am_q[cnt_q[1]*32 +: 32] * bm_q[cnt_q[0]*32 +: 32];
		pp_sh = {64'd0, pp} << {({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]}), 5'd0};
	end

	// floor shift of the magnitude product
	always_comb begin
		unique case (sh_q)
			SH_16:   rnd = (acc_q >> 16) + {127'd0, neg_q && (|acc_q[15:0])};
			SH_32:   rnd = (acc_q >> 32) + {127'd0, neg_q && (|acc_q[31:0])};
			default: rnd = acc_q;
		endcase
	end

	always_comb begin
		if (!neg_q) begin
			packed_res = (acc_q > 128'h7FFF_FFFF_FFFF_FFFF) ?
				64'h7FFF_FFFF_FFFF_FFFF : acc_q[63:0];
		end else begin
			packed_res = (acc_q >= 128'h8000_0000_0000_0000) ?
				64'h8000_0000_0000_0000 : (~acc_q[63:0] + 64'd1);
		end
	end

	// restoring divide step
	always_comb begin
		rsh   = {rem_q, dvd_q[95]};
		rdiff = rsh - {1'b0, bm_q};
		ge    = (rsh >= {1'b0, bm_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rda_q <= rf_q[cmd.ra];
			rdb_q <= rf_q[cmd.rb];
		end
		if (ph_q == PH_FIN) begin
			rf_q[dst_q] <= res_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cur_q  <= batt_current;
			volt_q <= batt_voltage;
		end
		if ((ph_q == PH_PUB) && slot_free) begin
			ocv_estimate        <= rda_q[47:0];
			resistance_estimate <= rdb_q[47:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((ph_q == PH_PUB) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (ph_q)
				PH_IDLE: begin
					if (cmd.start) begin
						dst_q <= cmd.dst;
						sh_q  <= cmd.sh;
						neg_q <= rda_q[63] ^ rdb_q[63];
						acc_q <= '0;
						unique case (cmd.op)
							OP_MUL: begin
								am_q  <= mag(rda_q);
								bm_q  <= mag(rdb_q);
								cnt_q <= '0;
								ph_q  <= PH_MUL;
							end
							OP_DIV: begin
								if (rdb_q == '0) begin
									res_q <= '0;
									ph_q  <= PH_FIN;
								end else begin
									dvd_q <= {mag(rda_q), 32'd0};
									bm_q  <= mag(rdb_q);
									rem_q <= '0;
									cnt_q <= 7'd95;
									ph_q  <= PH_DIV;
								end
							end
							OP_PUB: ph_q <= PH_PUB;
							default: begin
								res_q <= alu_res;
								ph_q  <= PH_FIN;
							end
						endcase
					end
				end
				PH_MUL: begin
					acc_q <= acc_q + pp_sh;
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q[1:0] == 2'd3) ph_q <= PH_MSH;
				end
				PH_MSH: begin
					acc_q <= rnd;
					ph_q  <= PH_PACK;
				end
				PH_DIV: begin
					rem_q <= ge ? rdiff[63:0] : rsh[63:0];
					acc_q <= {acc_q[126:0], ge};
					dvd_q <= {dvd_q[94:0], 1'b0};
					if (cnt_q == '0) ph_q <= PH_PACK;
					else cnt_q <= cnt_q - 7'd1;
				end
				PH_PACK: begin
					res_q <= packed_res;
					ph_q  <= PH_FIN;
				end
				PH_FIN: ph_q <= PH_IDLE;
				PH_PUB: begin
					if (slot_free) ph_q <= PH_IDLE;
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

endmodule

/* rtl/recursive_ocv_resistance_estimator.sv */
// Top level: two-parameter recursive least squares fit of ocv and resistance.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   batt_current, batt_voltage
//  out      output     out_valid / out_stall ocv_estimate, resistance_estimate
//
// One sample per beat, one result beat per sample. Each sample runs the
// microcode sequence to its publish before the next sample can be taken:
// 12 products on the shared 32x32 multiplier, two 96-step radix-2 divides
// for the gains (skipped with a zero gain when the denominator is zero),
// 19 ALU steps and a publish, all through the one register file.
// After reset a 6-step init program loads the covariance and estimates
// with in_stall high.
// in_stall is low only when the sequencer is idle; the result sits in the
// output register, and the next sample runs until it must publish, where
// it waits while out_stall holds the previous beat.
module recursive_ocv_resistance_estimator import roe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] batt_current,
	input  logic [15:0]        batt_voltage,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [47:0] ocv_estimate,
	output logic signed [47:0] resistance_estimate
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: walks the microcode, one step at a time
	roe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// register file plus shared arithmetic units and the output register
	roe_datapath u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.stat                (stat),
		.batt_current        (batt_current),
		.batt_voltage        (batt_voltage),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.ocv_estimate        (ocv_estimate),
		.resistance_estimate (resistance_estimate)
	);

endmodule
